// File: src/qat_pkg.sv
package qat_pkg;

    typedef enum logic [3:0] {
        M_SKIP = 4'd0,
        M_BARE = 4'd1,
        M_DQ   = 4'd2,
        M_SQ   = 4'd3,
        M_SQD  = 4'd4,
        M_ESC  = 4'd5,
        M_OCT1 = 4'd6,
        M_OCT2 = 4'd7,
        M_HEX1 = 4'd8,
        M_HEX2 = 4'd9
    } t_mode;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_NOARG = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_F  = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] esc;
        logic       emit;
        logic [1:0] kind;
        logic [7:0] value;
    } t_step;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// File: src/qat_step.sv
module qat_step import qat_pkg::*; (
    input  logic [7:0] i_ch,
    input  t_mode      i_mode,
    input  logic [7:0] i_esc,
    output t_step      o_res
);

    t_step      bare;
    logic [3:0] hex_d;
    logic       hex_ok;
    logic       oct_ok;

    // bare-mode handling, shared by skip and bare
    always_comb begin
        bare       = '0;
        bare.mode  = M_BARE;
        bare.esc   = i_esc;
        bare.kind  = KIND_DATA;
        if (is_ws(i_ch)) begin
            bare.mode = M_SKIP;
            bare.emit = 1'b1;
            bare.kind = KIND_END;
        end else if (i_ch == CH_DQ) begin
            bare.mode = M_DQ;
        end else if (i_ch == CH_SQ) begin
            bare.mode = M_SQ;
        end else begin
            bare.emit  = 1'b1;
            bare.value = i_ch;
        end
    end

    always_comb begin
        oct_ok = (i_ch >= CH_0) && (i_ch <= CH_7);
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (i_ch >= CH_0 && i_ch <= CH_9) begin
            hex_d = i_ch[3:0];
        end else if ((i_ch >= CH_UA && i_ch <= CH_UF) || (i_ch >= CH_LA && i_ch <= CH_LF_F)) begin
            hex_d = i_ch[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        o_res       = '0;
        o_res.mode  = i_mode;
        o_res.esc   = i_esc;
        o_res.kind  = KIND_DATA;
        if (i_ch == CH_NUL) begin
            o_res.mode = M_SKIP;
            o_res.emit = 1'b1;
            o_res.kind = (i_mode == M_SKIP) ? KIND_NOARG : KIND_END;
        end else begin
            unique case (i_mode)
                M_BARE: begin
                    o_res = bare;
                end
                M_DQ: begin
                    if (i_ch == CH_DQ) begin
                        o_res.mode = M_BARE;
                    end else if (i_ch == CH_SQ) begin
                        o_res.mode = M_SQD;
                    end else if (i_ch == CH_BSL) begin
                        o_res.mode = M_ESC;
                    end else begin
                        o_res.emit  = 1'b1;
                        o_res.value = i_ch;
                    end
                end
                M_SQ, M_SQD: begin
                    if (i_ch == CH_SQ) begin
                        o_res.mode = (i_mode == M_SQ) ? M_BARE : M_DQ;
                    end else begin
                        o_res.emit  = 1'b1;
                        o_res.value = i_ch;
                    end
                end
                M_ESC: begin
                    if (i_ch >= CH_0 && i_ch <= CH_3) begin
                        o_res.esc  = {6'd0, i_ch[1:0]};
                        o_res.mode = M_OCT1;
                    end else if (i_ch == CH_X) begin
                        o_res.esc  = 8'd0;
                        o_res.mode = M_HEX1;
                    end else begin
                        o_res.mode = M_DQ;
                        o_res.emit = 1'b1;
                        priority if (i_ch == CH_N) begin
                            o_res.value = CH_LF;
                        end else if (i_ch == CH_R) begin
                            o_res.value = CH_CR;
                        end else if (i_ch == CH_T) begin
                            o_res.value = CH_TAB;
                        end else begin
                            o_res.value = i_ch;
                        end
                    end
                end
                M_OCT1, M_OCT2: begin
                    if (oct_ok) begin
                        o_res.esc = {i_esc[4:0], i_ch[2:0]};
                    end
                    if (i_mode == M_OCT2) begin
                        o_res.mode  = M_DQ;
                        o_res.emit  = 1'b1;
                        o_res.value = o_res.esc;
                    end else begin
                        o_res.mode = M_OCT2;
                    end
                end
                M_HEX1, M_HEX2: begin
                    if (hex_ok) begin
                        o_res.esc = {i_esc[3:0], hex_d};
                    end
                    if (i_mode == M_HEX2) begin
                        o_res.mode  = M_DQ;
                        o_res.emit  = 1'b1;
                        o_res.value = o_res.esc;
                    end else begin
                        o_res.mode = M_HEX2;
                    end
                end
                default: begin
                    if (is_ws(i_ch)) begin
                        o_res.mode = M_SKIP;
                    end else begin
                        o_res = bare;
                    end
                end
            endcase
        end
    end

endmodule

// File: src/quoted_argument_tokenizer.sv
// Between input accept and result valid lie the input register and the result register.
// One character per cycle unless output stalls; mode and escape value update in one pass.
// Characters that produce nothing (quotes, escape prefixes, skipped spaces) give no result.
// Reset (i_rst_n low, synchronous) empties both registers and returns to skip mode.
module quoted_argument_tokenizer import qat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_value
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    t_mode      r_mode;
    logic [7:0] r_esc;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_value;
    logic       advance;
    t_step      res;

    qat_step u_step (
        .i_ch   (r_ch),
        .i_mode (r_mode),
        .i_esc  (r_esc),
        .o_res  (res)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_SKIP;
            r_esc  <= 8'd0;
        end else if (advance) begin
            r_mode <= res.mode;
            r_esc  <= res.esc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.emit) begin
            r_kind  <= res.kind;
            r_value <= res.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;

endmodule

// File: sim/qat_token_checker.sv
module qat_token_checker import qat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_value,
    output int         o_pending,
    output int         o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    t_mode      parse_mode;
    logic [7:0] escape_acc;
    t_step      expected_tokens[$];
    int         error_count = 0;

    function automatic t_step tokenize_char(input t_mode mode, input logic [7:0] esc,
                                            input logic [7:0] c);
        t_step      s;
        logic       ws;
        logic [4:0] digit;
        s.mode  = mode;
        s.esc   = esc;
        s.emit  = 1'b0;
        s.kind  = KIND_DATA;
        s.value = 8'd0;
        ws      = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        digit   = 5'd16;
        if (c == CH_NUL) begin
            s.mode = M_SKIP;
            s.emit = 1'b1;
            s.kind = (mode == M_SKIP) ? KIND_NOARG : KIND_END;
            return s;
        end
        case (mode)
            M_DQ: begin
                if (c == CH_DQ) s.mode = M_BARE;
                else if (c == CH_SQ) s.mode = M_SQD;
                else if (c == CH_BSL) s.mode = M_ESC;
                else begin
                    s.emit  = 1'b1;
                    s.value = c;
                end
            end
            M_SQ, M_SQD: begin
                if (c == CH_SQ) begin
                    s.mode = (mode == M_SQ) ? M_BARE : M_DQ;
                end else begin
                    s.emit  = 1'b1;
                    s.value = c;
                end
            end
            M_ESC: begin
                if (c >= CH_0 && c <= CH_3) begin
                    s.esc  = c - CH_0;
                    s.mode = M_OCT1;
                end else if (c == CH_X) begin
                    s.esc  = 8'd0;
                    s.mode = M_HEX1;
                end else begin
                    s.mode  = M_DQ;
                    s.emit  = 1'b1;
                    s.value = (c == CH_N) ? CH_LF : (c == CH_R) ? CH_CR :
                              (c == CH_T) ? CH_TAB : c;
                end
            end
            M_OCT1, M_OCT2: begin
                if (c >= CH_0 && c <= CH_7) s.esc = {esc[4:0], c[2:0]};
                if (mode == M_OCT2) begin
                    s.mode  = M_DQ;
                    s.emit  = 1'b1;
                    s.value = s.esc;
                end else begin
                    s.mode = M_OCT2;
                end
            end
            M_HEX1, M_HEX2: begin
                if (c >= CH_0 && c <= CH_9) digit = 5'(c - CH_0);
                else if (c >= CH_UA && c <= CH_UF) digit = 5'(c - CH_UA + 8'd10);
                else if (c >= CH_LA && c <= CH_LF_F) digit = 5'(c - CH_LA + 8'd10);
                if (digit < 5'd16) s.esc = {esc[3:0], digit[3:0]};
                if (mode == M_HEX2) begin
                    s.mode  = M_DQ;
                    s.emit  = 1'b1;
                    s.value = s.esc;
                end else begin
                    s.mode = M_HEX2;
                end
            end
            default: begin
                // skip and bare share the argument-start handling
                if (ws) begin
                    s.mode = M_SKIP;
                    if (mode == M_BARE) begin
                        s.emit = 1'b1;
                        s.kind = KIND_END;
                    end
                end else if (c == CH_DQ) begin
                    s.mode = M_DQ;
                end else if (c == CH_SQ) begin
                    s.mode = M_SQ;
                end else begin
                    s.mode  = M_BARE;
                    s.emit  = 1'b1;
                    s.value = c;
                end
            end
        endcase
        return s;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_step s;
        t_step want;
        if (!i_rst_n) begin
            parse_mode = M_SKIP;
            escape_acc = 8'd0;
            expected_tokens.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected item: kind %0d value 0x%02h", i_kind, i_value);
                    error_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, i_kind);
                        error_count++;
                    end
                    if (i_value !== want.value) begin
                        $error("value: expected 0x%02h, actual 0x%02h", want.value, i_value);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                s = tokenize_char(parse_mode, escape_acc, i_ch);
                parse_mode = s.mode;
                escape_acc = s.esc;
                if (s.emit) expected_tokens.push_back(s);
            end
        end
        o_pending <= expected_tokens.size();
        o_errors  <= error_count;
    end

endmodule

// File: sim/quoted_argument_tokenizer_tb.sv
module quoted_argument_tokenizer_tb import qat_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_byte_q[$];

    localparam int N_ITEMS     = 1100;
    localparam int HOLD_CYCLES = 300;
    localparam int BURST_ITEMS = 80;
    localparam int STALL_LIMIT = 4000;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_ch        = 8'd0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_value;

    int pending;
    int errors;
    int n_sent      = 0;
    int hold_cycles = 0;
    int idle_count  = 0;
    bit send_idle   = 1'b1;
    bit recv_idle   = 1'b1;

    always #10ns i_clk = ~i_clk;

    quoted_argument_tokenizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_ch       (i_ch),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_kind     (o_kind),
        .o_value    (o_value)
    );

    qat_token_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_ready (o_in_ready),
        .i_ch       (i_ch),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_kind     (o_kind),
        .i_value    (o_value),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= STALL_LIMIT) begin
            $display("quoted_argument_tokenizer_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
        do c = 8'($urandom_range(33, 126)); while (c == CH_DQ || c == CH_SQ || c == CH_BSL);
        return c;
    endfunction

    function automatic logic [7:0] verbatim_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_SQ);
        return c;
    endfunction

    task automatic compose_line(output t_byte_q text);
        int n_args;
        int h;
        text = {};
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
            text.push_back(CH_NUL);
            return;
        end
        repeat ($urandom_range(0, 2)) text.push_back(space_char());
        n_args = $urandom_range(1, 4);
        for (int a = 0; a < n_args; a++) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: repeat ($urandom_range(1, 5))
                        text.push_back(($urandom_range(0, 7) == 0) ? CH_BSL : plain_char());
                    1: begin
                        text.push_back(CH_DQ);
                        repeat ($urandom_range(0, 6)) begin
                            case ($urandom_range(0, 5))
                                0, 1: text.push_back(plain_char());
                                2: text.push_back(space_char());
                                3: begin
                                    text.push_back(CH_SQ);
                                    repeat ($urandom_range(0, 3)) text.push_back(verbatim_char());
                                    text.push_back(CH_SQ);
                                end
                                default: begin
                                    text.push_back(CH_BSL);
                                    case ($urandom_range(0, 6))
                                        0: text.push_back(CH_BSL);
                                        1: text.push_back(($urandom_range(0, 2) == 0) ? CH_N :
                                                          ($urandom_range(0, 1) == 0) ? CH_R : CH_T);
                                        2: text.push_back(CH_SQ);
                                        3: text.push_back(CH_DQ);
                                        4: begin
                                            text.push_back(CH_0 + 8'($urandom_range(0, 3)));
                                            repeat (2)
                                                text.push_back(($urandom_range(0, 5) == 0) ?
                                                    8'($urandom_range(1, 255)) :
                                                    CH_0 + 8'($urandom_range(0, 7)));
                                        end
                                        5: begin
                                            text.push_back(CH_X);
                                            repeat (2) begin
                                                h = $urandom_range(0, 21);
                                                if ($urandom_range(0, 5) == 0)
                                                    text.push_back(8'($urandom_range(1, 255)));
                                                else if (h < 10)
                                                    text.push_back(CH_0 + 8'(h));
                                                else if (h < 16)
                                                    text.push_back(CH_UA + 8'(h - 10));
                                                else
                                                    text.push_back(CH_LA + 8'(h - 16));
                                            end
                                        end
                                        default: text.push_back(8'($urandom_range(1, 255)));
                                    endcase
                                end
                            endcase
                        end
                        text.push_back(CH_DQ);
                    end
                    default: begin
                        text.push_back(CH_SQ);
                        repeat ($urandom_range(0, 5)) text.push_back(verbatim_char());
                        text.push_back(CH_SQ);
                    end
                endcase
            end
            if (a < n_args - 1 || $urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 3)) text.push_back(space_char());
        end
        // broken line: cut anywhere, even inside quotes or an escape
        if ($urandom_range(0, 7) == 0) text = text[0:$urandom_range(0, text.size() - 1)];
        text.push_back(CH_NUL);
    endtask

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = send_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    task automatic send_text(input t_byte_q text);
        foreach (text[k]) send_char(text[k]);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : receiver
        int stall;
        repeat (5) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = recv_idle ? $urandom_range(0, 16) : 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        t_byte_q text;
        t_byte_q directed;
        int      bursts;
        int      start;
        bursts   = 0;
        directed = '{CH_NUL, CH_SPACE, CH_TAB, 8'h61, 8'h80, 8'hFF, CH_CR,
                     CH_DQ, CH_BSL, CH_T, CH_BSL, CH_X, CH_LF_F, 8'h47,
                     CH_BSL, CH_3, 8'h38, CH_7, CH_SQ, 8'h7A, CH_SQ,
                     CH_BSL, CH_DQ, CH_DQ, CH_SQ, 8'h71, CH_NUL};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_text(directed);
        while (n_sent < N_ITEMS) begin
            if ((bursts == 0 && n_sent >= 400) || (bursts == 1 && n_sent >= 800)) begin
                // let the pipe empty, then stall the output and push hard
                drain_results();
                hold_cycles = HOLD_CYCLES;
                send_idle   = 1'b0;
                start       = n_sent;
                while (n_sent - start < BURST_ITEMS) begin
                    compose_line(text);
                    send_text(text);
                end
                bursts++;
            end else begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
                compose_line(text);
                send_text(text);
            end
        end
        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("quoted_argument_tokenizer_tb OK");
        end else begin
            $display("quoted_argument_tokenizer_tb NOT OK");
        end
        $finish;
    end

endmodule
